[design/ssd_pkg.sv]
// Shared widths, latencies and types for the 3D segment distance pipeline.
// No dependencies; ssd_frac, ssd_sqrt and the top module refer to this package by scope.
package ssd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int PAR_FRAC   = 32;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int WIDE_W = 2 * DOT_W;
  localparam int FRAC_W = PAR_FRAC + 1;
  localparam int CMP_W  = DIFF_W + PAR_FRAC + 3;
  localparam int SQR_W  = 2 * CMP_W;
  localparam int SHIFT  = 2 * PAR_FRAC - 2 - 2 * FRAC_BITS;
  localparam int RAD_W  = SQR_W - SHIFT;
  localparam int ROOT_W = RAD_W / 2;
  localparam int DIST_W = 33;

  localparam int MUL_LAT  = 4;
  localparam int FRAC_LAT = FRAC_W + 2;
  localparam int SQRT_LAT = ROOT_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;
  typedef logic [FRAC_W-1:0]            frac_t;

endpackage

[design/ssd_dly.sv]
// Fixed-length register delay line that keeps side data aligned with the
// pipelined arithmetic units. No dependencies.
module ssd_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] d_r [N];

  always_ff @(posedge clk) begin
    d_r[0] <= d_i;
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk) begin
      d_r[i] <= d_r[i-1];
    end
  end

  assign d_o = d_r[N-1];

endmodule

[design/ssd_mul.sv]
// Signed multiplier cut into half-width partial products over four stages.
// One operand pair per cycle.
module ssd_mul #(
  parameter int W = 36
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int H = (W + 1) / 2;

  logic [W-1:0]     ma_w, mb_w;
  logic [2*H-1:0]   ma_r, mb_r;
  logic             neg_r, neg2_r, neg3_r;
  logic [2*H-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [4*H-1:0]   sum_nxt, sum_r;
  logic [2*W-1:0]   prod_r;

  assign ma_w = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mb_w = b_i[W-1] ? W'(-b_i) : W'(b_i);

  assign sum_nxt = {p11_r, {(2*H){1'b0}}}
                 + (((4*H)'(p01_r) + (4*H)'(p10_r)) << H)
                 + (4*H)'(p00_r);

  always_ff @(posedge clk) begin
    ma_r   <= (2*H)'(ma_w);
    mb_r   <= (2*H)'(mb_w);
    neg_r  <= a_i[W-1] ^ b_i[W-1];
    p00_r  <= ma_r[H-1:0] * mb_r[H-1:0];
    p01_r  <= ma_r[H-1:0] * mb_r[2*H-1:H];
    p10_r  <= ma_r[2*H-1:H] * mb_r[H-1:0];
    p11_r  <= ma_r[2*H-1:H] * mb_r[2*H-1:H];
    neg2_r <= neg_r;
    sum_r  <= sum_nxt;
    neg3_r <= neg2_r;
    prod_r <= neg3_r ? -((2*W)'(sum_r)) : (2*W)'(sum_r);
  end

  assign p_o = prod_r;

endmodule

[design/ssd_frac.sv]
// Pipelined restoring divider giving num/den in [0,1] with PAR_FRAC
// fractional bits, rounded to nearest. Depends on ssd_pkg.
module ssd_frac (
  input  logic           clk,
  input  ssd_pkg::wide_t num_i,
  input  ssd_pkg::wide_t den_i,
  output ssd_pkg::frac_t frac_o
);

  localparam int STEPS = ssd_pkg::FRAC_W;
  localparam int RW    = ssd_pkg::WIDE_W + 1;
  localparam ssd_pkg::frac_t ONE = ssd_pkg::FRAC_W'(1) << ssd_pkg::PAR_FRAC;

  logic [RW-1:0]              rem_r  [STEPS+1];
  logic [ssd_pkg::WIDE_W-1:0] den_r  [STEPS+1];
  ssd_pkg::frac_t             q_r    [STEPS+1];
  logic                       zero_r [STEPS+1];
  logic                       one_r  [STEPS+1];
  logic [ssd_pkg::FRAC_W:0]   q_inc;
  ssd_pkg::frac_t             frac_r;

  always_ff @(posedge clk) begin
    rem_r[0]  <= {1'b0, num_i};
    den_r[0]  <= den_i;
    q_r[0]    <= '0;
    zero_r[0] <= (num_i <= 0) || (den_i <= 0);
    one_r[0]  <= num_i >= den_i;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem_r[i][RW-2:0], 1'b0};
    assign ge = sh >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= ge ? sh - {1'b0, den_r[i]} : sh;
      den_r[i+1]  <= den_r[i];
      q_r[i+1]    <= {q_r[i][ssd_pkg::FRAC_W-2:0], ge};
      zero_r[i+1] <= zero_r[i];
      one_r[i+1]  <= one_r[i];
    end
  end

  assign q_inc = (ssd_pkg::FRAC_W+1)'(q_r[STEPS]) + 1'b1;

  always_ff @(posedge clk) begin
    if (zero_r[STEPS]) begin
      frac_r <= '0;
    end else if (one_r[STEPS]) begin
      frac_r <= ONE;
    end else begin
      frac_r <= q_inc[ssd_pkg::FRAC_W:1];
    end
  end

  assign frac_o = frac_r;

endmodule

[design/ssd_sqrt.sv]
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on ssd_pkg.
module ssd_sqrt (
  input  logic                       clk,
  input  logic [ssd_pkg::RAD_W-1:0]  rad_i,
  output logic [ssd_pkg::ROOT_W-1:0] root_o
);

  localparam int STEPS = ssd_pkg::ROOT_W;
  localparam int RW    = ssd_pkg::RAD_W;

  logic [RW-1:0] x_r   [STEPS+1];
  logic [RW-1:0] res_r [STEPS+1];

  always_ff @(posedge clk) begin
    x_r[0]   <= rad_i;
    res_r[0] <= '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * i);
    logic [RW-1:0] t;
    logic          ge;
    assign t  = res_r[i] + BIT;
    assign ge = x_r[i] >= t;
    always_ff @(posedge clk) begin
      x_r[i+1]   <= ge ? x_r[i] - t : x_r[i];
      res_r[i+1] <= ge ? (res_r[i] >> 1) + BIT : res_r[i] >> 1;
    end
  end

  assign root_o = res_r[STEPS][STEPS-1:0];

endmodule

[design/segment_segment_distance_3d.sv]
// Least distance between two 3D segments, fully pipelined.
// Throughput one transaction per cycle.
// Depth is set by the 33-step parameter dividers and the 37-step square root.
// busy stays low; the receiver cannot stall, so nothing ever holds the pipeline.
// rst_n (synchronous) clears only the valid bits; transactions in flight are dropped.
module segment_segment_distance_3d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ssd_pkg::coord_t               in_seg1_start_x,
  input  ssd_pkg::coord_t               in_seg1_start_y,
  input  ssd_pkg::coord_t               in_seg1_start_z,
  input  ssd_pkg::coord_t               in_seg1_end_x,
  input  ssd_pkg::coord_t               in_seg1_end_y,
  input  ssd_pkg::coord_t               in_seg1_end_z,
  input  ssd_pkg::coord_t               in_seg2_start_x,
  input  ssd_pkg::coord_t               in_seg2_start_y,
  input  ssd_pkg::coord_t               in_seg2_start_z,
  input  ssd_pkg::coord_t               in_seg2_end_x,
  input  ssd_pkg::coord_t               in_seg2_end_y,
  input  ssd_pkg::coord_t               in_seg2_end_z,
  output logic                          out_strobe,
  output logic [ssd_pkg::DIST_W-1:0]    out_distance
);

  localparam int DW  = ssd_pkg::DIFF_W;
  localparam int PW  = ssd_pkg::PROD_W;
  localparam int TW  = ssd_pkg::DOT_W;
  localparam int XW  = ssd_pkg::WIDE_W;
  localparam int CW  = ssd_pkg::CMP_W;
  localparam int QW  = ssd_pkg::SQR_W;
  localparam int RTW = ssd_pkg::ROOT_W;
  localparam int UVW_DLY  = 2 + ssd_pkg::MUL_LAT + 3 + ssd_pkg::FRAC_LAT;
  localparam int FRAC_STG = UVW_DLY;
  localparam int LAT = FRAC_STG + ssd_pkg::MUL_LAT + ssd_pkg::SQRT_LAT + 5;
  localparam logic [RTW-1:0] DIST_MAX = RTW'({ssd_pkg::DIST_W{1'b1}});
  localparam ssd_pkg::frac_t FRAC_ONE = ssd_pkg::FRAC_W'(1) << ssd_pkg::PAR_FRAC;

  ssd_pkg::coord_t p0 [3], p1 [3], q0 [3], q1 [3];
  ssd_pkg::diff_t  u_r [3], v_r [3], w_r [3];
  ssd_pkg::prod_t  uu_r [3], uv_r [3], vv_r [3], uw_r [3], vw_r [3];
  ssd_pkg::dot_t   a_r, b_r, c_r, d_r, e_r;
  ssd_pkg::dot_t   a_d, b_d, c_d, d_d, e_d;
  logic [5*TW-1:0] dots_d;
  ssd_pkg::wide_t  ac_w, bb_w, be_w, cd_w, ae_w, bd_w;
  ssd_pkg::wide_t  det_r, sn0_r, tn0_r;
  ssd_pkg::dot_t   a8_r, b8_r, c8_r, d8_r, e8_r;
  ssd_pkg::wide_t  sna_r, sda_r, tna_r, tda_r;
  ssd_pkg::dot_t   a9_r, d9_r;
  logic signed [TW:0] k9_r, nd9_r;
  ssd_pkg::wide_t  sna_nxt, sda_nxt, tna_nxt, tda_nxt;
  ssd_pkg::wide_t  sn_r, sd_r, tn_r, td_r;
  ssd_pkg::wide_t  sn_nxt, sd_nxt, tn_nxt;
  ssd_pkg::frac_t  sc_w, tc_w;
  logic [9*DW-1:0] uvw_d;
  ssd_pkg::diff_t  u_d [3], v_d [3], w_d [3];
  ssd_pkg::cmp_t   sc_x, tc_x;
  ssd_pkg::cmp_t   pu_r [3], pv_r [3];
  ssd_pkg::diff_t  wd_r [3];
  ssd_pkg::cmp_t   cmp_r [3];
  logic signed [QW-1:0] sq_w [3];
  logic [QW-1:0]   sum_r;
  logic [RTW-1:0]  root_w;
  logic [RTW:0]    rnd_w;
  logic [RTW-1:0]  dist_w;
  logic [ssd_pkg::DIST_W-1:0] dist_r;
  logic [LAT-1:0]  vld_r, vld_nxt;

  assign p0 = '{in_seg1_start_x, in_seg1_start_y, in_seg1_start_z};
  assign p1 = '{in_seg1_end_x, in_seg1_end_y, in_seg1_end_z};
  assign q0 = '{in_seg2_start_x, in_seg2_start_y, in_seg2_start_z};
  assign q1 = '{in_seg2_end_x, in_seg2_end_y, in_seg2_end_z};

  assign busy = 1'b0;

  for (genvar i = 0; i < 3; i++) begin : g_vec
    always_ff @(posedge clk) begin
      u_r[i]  <= DW'(p1[i]) - DW'(p0[i]);
      v_r[i]  <= DW'(q1[i]) - DW'(q0[i]);
      w_r[i]  <= DW'(p0[i]) - DW'(q0[i]);
      uu_r[i] <= PW'(u_r[i]) * PW'(u_r[i]);
      uv_r[i] <= PW'(u_r[i]) * PW'(v_r[i]);
      vv_r[i] <= PW'(v_r[i]) * PW'(v_r[i]);
      uw_r[i] <= PW'(u_r[i]) * PW'(w_r[i]);
      vw_r[i] <= PW'(v_r[i]) * PW'(w_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    a_r <= TW'(uu_r[0]) + TW'(uu_r[1]) + TW'(uu_r[2]);
    b_r <= TW'(uv_r[0]) + TW'(uv_r[1]) + TW'(uv_r[2]);
    c_r <= TW'(vv_r[0]) + TW'(vv_r[1]) + TW'(vv_r[2]);
    d_r <= TW'(uw_r[0]) + TW'(uw_r[1]) + TW'(uw_r[2]);
    e_r <= TW'(vw_r[0]) + TW'(vw_r[1]) + TW'(vw_r[2]);
  end

  ssd_mul #(.W(TW)) u_mul_ac (.clk(clk), .a_i(a_r), .b_i(c_r), .p_o(ac_w));
  ssd_mul #(.W(TW)) u_mul_bb (.clk(clk), .a_i(b_r), .b_i(b_r), .p_o(bb_w));
  ssd_mul #(.W(TW)) u_mul_be (.clk(clk), .a_i(b_r), .b_i(e_r), .p_o(be_w));
  ssd_mul #(.W(TW)) u_mul_cd (.clk(clk), .a_i(c_r), .b_i(d_r), .p_o(cd_w));
  ssd_mul #(.W(TW)) u_mul_ae (.clk(clk), .a_i(a_r), .b_i(e_r), .p_o(ae_w));
  ssd_mul #(.W(TW)) u_mul_bd (.clk(clk), .a_i(b_r), .b_i(d_r), .p_o(bd_w));

  ssd_dly #(.W(5*TW), .N(ssd_pkg::MUL_LAT)) u_dly_dots (
    .clk(clk),
    .d_i({a_r, b_r, c_r, d_r, e_r}),
    .d_o(dots_d)
  );

  assign {a_d, b_d, c_d, d_d, e_d} = dots_d;

  always_ff @(posedge clk) begin
    det_r <= ac_w - bb_w;
    sn0_r <= be_w - cd_w;
    tn0_r <= ae_w - bd_w;
    a8_r  <= a_d;
    b8_r  <= b_d;
    c8_r  <= c_d;
    d8_r  <= d_d;
    e8_r  <= e_d;
  end

  always_comb begin
    if (det_r <= 0) begin
      sna_nxt = '0;
      sda_nxt = XW'(1);
      tna_nxt = XW'(e8_r);
      tda_nxt = XW'(c8_r);
    end else begin
      sda_nxt = det_r;
      tda_nxt = det_r;
      sna_nxt = sn0_r;
      tna_nxt = tn0_r;
      if (sn0_r <= 0) begin
        sna_nxt = '0;
        tna_nxt = XW'(e8_r);
        tda_nxt = XW'(c8_r);
      end else if (sn0_r > det_r) begin
        sna_nxt = det_r;
        tna_nxt = XW'(e8_r) + XW'(b8_r);
        tda_nxt = XW'(c8_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    sna_r <= sna_nxt;
    sda_r <= sda_nxt;
    tna_r <= tna_nxt;
    tda_r <= tda_nxt;
    a9_r  <= a8_r;
    d9_r  <= d8_r;
    k9_r  <= (TW+1)'(b8_r) - (TW+1)'(d8_r);
    nd9_r <= -((TW+1)'(d8_r));
  end

  always_comb begin
    sn_nxt = sna_r;
    sd_nxt = sda_r;
    tn_nxt = tna_r;
    if (tna_r > tda_r) begin
      tn_nxt = tda_r;
      if (k9_r <= 0) begin
        sn_nxt = '0;
      end else if (k9_r > (TW+1)'(a9_r)) begin
        sn_nxt = sda_r;
      end else begin
        sn_nxt = XW'(k9_r);
        sd_nxt = XW'(a9_r);
      end
    end else if (tna_r <= 0) begin
      tn_nxt = '0;
      if (d9_r > 0) begin
        sn_nxt = '0;
      end else if (nd9_r > (TW+1)'(a9_r)) begin
        sn_nxt = sda_r;
      end else begin
        sn_nxt = XW'(nd9_r);
        sd_nxt = XW'(a9_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    sn_r <= sn_nxt;
    sd_r <= sd_nxt;
    tn_r <= tn_nxt;
    td_r <= tda_r;
  end

  ssd_frac u_frac_s (.clk(clk), .num_i(sn_r), .den_i(sd_r), .frac_o(sc_w));
  ssd_frac u_frac_t (.clk(clk), .num_i(tn_r), .den_i(td_r), .frac_o(tc_w));

  ssd_dly #(.W(9*DW), .N(UVW_DLY)) u_dly_uvw (
    .clk(clk),
    .d_i({u_r[0], u_r[1], u_r[2], v_r[0], v_r[1], v_r[2], w_r[0], w_r[1], w_r[2]}),
    .d_o(uvw_d)
  );

  assign {u_d[0], u_d[1], u_d[2], v_d[0], v_d[1], v_d[2], w_d[0], w_d[1], w_d[2]} = uvw_d;

  assign sc_x = CW'(sc_w);
  assign tc_x = CW'(tc_w);

  for (genvar i = 0; i < 3; i++) begin : g_cmp
    always_ff @(posedge clk) begin
      pu_r[i]  <= sc_x * CW'(u_d[i]);
      pv_r[i]  <= tc_x * CW'(v_d[i]);
      wd_r[i]  <= w_d[i];
      cmp_r[i] <= (CW'(wd_r[i]) <<< ssd_pkg::PAR_FRAC) + pu_r[i] - pv_r[i];
    end

    ssd_mul #(.W(CW)) u_mul_sq (.clk(clk), .a_i(cmp_r[i]), .b_i(cmp_r[i]), .p_o(sq_w[i]));
  end

  always_ff @(posedge clk) begin
    sum_r <= QW'(sq_w[0]) + QW'(sq_w[1]) + QW'(sq_w[2]);
  end

  ssd_sqrt u_sqrt (
    .clk(clk),
    .rad_i(sum_r[QW-1:ssd_pkg::SHIFT]),
    .root_o(root_w)
  );

  assign rnd_w  = (RTW+1)'(root_w) + 1'b1;
  assign dist_w = rnd_w[RTW:1];

  always_ff @(posedge clk) begin
    dist_r <= (dist_w > DIST_MAX) ? ssd_pkg::DIST_W'(DIST_MAX)
                                  : ssd_pkg::DIST_W'(dist_w);
  end

  assign vld_nxt = {vld_r[LAT-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_strobe   = vld_r[LAT-1];
  assign out_distance = dist_r;

  a_strobe_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result strobe without a matching start");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FRAC_STG] |-> (sc_w <= FRAC_ONE && tc_w <= FRAC_ONE))
    else $error("segment parameter above one");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (RTW'(out_distance) <= DIST_MAX))
    else $error("distance above saturation limit");

endmodule

[tb/tb_segment_segment_distance_3d.sv]
// Self-checking testbench for segment_segment_distance_3d: directed and random segment pairs.
// Depends on ssd_pkg for the coordinate type, the distance width and the fraction widths.
// The scoreboard class predicts every distance and checks the results in order.
module tb_segment_segment_distance_3d;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct {
    coord_t c[12];
  } seg_pair_t;

  typedef logic signed [127:0] s128_t;
  typedef logic [127:0]        u128_t;

  class distance_scoreboard;
    longint unsigned expected_dist[$];
    int              mismatches;
    int              checked;
    int              noted;

    function new();
      mismatches = 0;
      checked    = 0;
      noted      = 0;
    endfunction

    function longint unsigned param_fraction(s128_t num, s128_t den);
      u128_t q;
      if (num <= 0 || den <= 0) return 0;
      if (num >= den) return 64'd1 << PAR_FRAC;
      q = (u128_t'(num) << (PAR_FRAC + 1)) / u128_t'(den);
      return longint'((q + 1) >> 1);
    endfunction

    function longint unsigned min_distance(seg_pair_t s);
      longint          u[3], v[3], w[3];
      longint          a, b, c, d, e, k;
      s128_t           det, sN, sD, tN, tD, comp, bw, uw, vw, scw, tcw;
      u128_t           sum, rad, m, t;
      longint unsigned sc, tc, root, dist_q;
      a = 0; b = 0; c = 0; d = 0; e = 0;
      for (int i = 0; i < 3; i++) begin
        u[i] = longint'(s.c[3 + i]) - longint'(s.c[i]);
        v[i] = longint'(s.c[9 + i]) - longint'(s.c[6 + i]);
        w[i] = longint'(s.c[i]) - longint'(s.c[6 + i]);
        a += u[i] * u[i];
        b += u[i] * v[i];
        c += v[i] * v[i];
        d += u[i] * w[i];
        e += v[i] * w[i];
      end
      det = s128_t'(a) * s128_t'(c) - s128_t'(b) * s128_t'(b);
      if (det <= 0) begin
        sN = 0; sD = 1; tN = e; tD = c;
      end else begin
        sD = det; tD = det;
        sN = s128_t'(b) * s128_t'(e) - s128_t'(c) * s128_t'(d);
        tN = s128_t'(a) * s128_t'(e) - s128_t'(b) * s128_t'(d);
        if (sN <= 0) begin
          sN = 0; tN = e; tD = c;
        end else if (sN > sD) begin
          sN = sD; tN = e + b; tD = c;
        end
      end
      if (tN > tD) begin
        tN = tD;
        k = b - d;
        if (k <= 0) sN = 0;
        else if (k > a) sN = sD;
        else begin
          sN = k; sD = a;
        end
      end else if (tN <= 0) begin
        tN = 0;
        if (d > 0) sN = 0;
        else if (-d > a) sN = sD;
        else begin
          sN = -d; sD = a;
        end
      end
      sc  = param_fraction(sN, sD);
      tc  = param_fraction(tN, tD);
      scw = s128_t'({64'd0, sc});
      tcw = s128_t'({64'd0, tc});
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        bw   = w[i];
        uw   = u[i];
        vw   = v[i];
        comp = (bw <<< PAR_FRAC) + scw * uw - tcw * vw;
        m    = (comp < 0) ? u128_t'(-comp) : u128_t'(comp);
        sum  = sum + m * m;
      end
      rad  = sum >> (2 * PAR_FRAC - 2 - 2 * FRAC_BITS);
      root = 0;
      for (int i = 63; i >= 0; i--) begin
        t = {64'd0, root | (64'd1 << i)};
        if (t * t <= rad) root = t[63:0];
      end
      dist_q = (root + 1) >> 1;
      if (dist_q > 64'h1_FFFF_FFFF) dist_q = 64'h1_FFFF_FFFF;
      return dist_q;
    endfunction

    function void note_pair(seg_pair_t s);
      expected_dist.push_back(min_distance(s));
      noted++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_distance(logic [DIST_W-1:0] got);
      longint unsigned want;
      if (expected_dist.size() == 0) begin
        report_mismatch($sformatf("unexpected distance %0d", got));
      end else begin
        want = expected_dist.pop_front();
        checked++;
        if (64'(got) !== want)
          report_mismatch($sformatf("distance got %0d want %0d", got, want));
      end
    endtask
  endclass

  logic clk, rst_n, start, busy, out_strobe;
  coord_t in_s1sx, in_s1sy, in_s1sz, in_s1ex, in_s1ey, in_s1ez;
  coord_t in_s2sx, in_s2sy, in_s2sz, in_s2ex, in_s2ey, in_s2ez;
  logic [DIST_W-1:0] out_distance;

  distance_scoreboard sb;
  int idle_cycles;

  segment_segment_distance_3d dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seg1_start_x(in_s1sx), .in_seg1_start_y(in_s1sy), .in_seg1_start_z(in_s1sz),
    .in_seg1_end_x(in_s1ex), .in_seg1_end_y(in_s1ey), .in_seg1_end_z(in_s1ez),
    .in_seg2_start_x(in_s2sx), .in_seg2_start_y(in_s2sy), .in_seg2_start_z(in_s2sz),
    .in_seg2_end_x(in_s2ex), .in_seg2_end_y(in_s2ey), .in_seg2_end_z(in_s2ez),
    .out_strobe(out_strobe), .out_distance(out_distance)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    seg_pair_t seen;
    if (rst_n) begin
      if (start && !busy) begin
        seen.c = '{in_s1sx, in_s1sy, in_s1sz, in_s1ex, in_s1ey, in_s1ez,
                   in_s2sx, in_s2sy, in_s2sz, in_s2ex, in_s2ey, in_s2ez};
        sb.note_pair(seen);
      end
      if (out_strobe) sb.check_distance(out_distance);
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d distances outstanding", sb.expected_dist.size());
      $display("[segment_segment_distance_3d] ERROR");
      $finish;
    end
  end

  function automatic seg_pair_t make_pair(int p[12]);
    seg_pair_t s;
    for (int i = 0; i < 12; i++) s.c[i] = coord_t'(p[i]);
    return s;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic seg_pair_t random_pair();
    int p[12];
    int base, dx, dy, dz, k0, k1, k2, k3, span;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 12; i++) p[i] = rnd_coord();
    if (kind < 3) begin
      return make_pair(p);
    end else if (kind < 5) begin
      span = $urandom_range(1) ? 60 : 3000;
      base = int'($urandom_range(40000)) - 20000;
      for (int i = 0; i < 12; i++) p[i] = base + int'($urandom_range(2 * span)) - span;
    end else if (kind < 7) begin
      // parallel or collinear pair
      dx = int'($urandom_range(200)) - 100;
      dy = int'($urandom_range(200)) - 100;
      dz = int'($urandom_range(200)) - 100;
      k0 = int'($urandom_range(100)) - 50; k1 = int'($urandom_range(100)) - 50;
      k2 = int'($urandom_range(100)) - 50; k3 = int'($urandom_range(100)) - 50;
      base = int'($urandom_range(30000)) - 15000;
      for (int i = 0; i < 3; i++) begin
        p[i]     = base + ((i == 0) ? dx : (i == 1) ? dy : dz) * k0;
        p[3 + i] = base + ((i == 0) ? dx : (i == 1) ? dy : dz) * k1;
        p[6 + i] = base + ((i == 0) ? dx : (i == 1) ? dy : dz) * k2
                   + (($urandom_range(1) == 1) ? int'($urandom_range(20)) : 0);
        p[9 + i] = p[6 + i] + ((i == 0) ? dx : (i == 1) ? dy : dz) * (k3 - k2);
      end
    end else if (kind < 8) begin
      // per coordinate, an end point may copy its start point, so either segment may have zero length
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(2) != 0) p[3 + i] = p[i];
        if ($urandom_range(2) == 0) p[9 + i] = p[6 + i];
      end
    end else if (kind < 9) begin
      // seg2 start takes each coordinate from seg1 start or seg1 end, chosen per coordinate
      for (int i = 0; i < 3; i++) p[6 + i] = p[3 * $urandom_range(1) + i];
    end else begin
      for (int i = 0; i < 12; i++)
        if ($urandom_range(1) == 1) p[i] = $urandom_range(1) ? 32767 : -32768;
    end
    return make_pair(p);
  endfunction

  task automatic send_pair(seg_pair_t s, int gap_pct);
    while (int'($urandom_range(99)) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    {in_s1sx, in_s1sy, in_s1sz, in_s1ex, in_s1ey, in_s1ez} <=
      {s.c[0], s.c[1], s.c[2], s.c[3], s.c[4], s.c[5]};
    {in_s2sx, in_s2sy, in_s2sz, in_s2ex, in_s2ey, in_s2ez} <=
      {s.c[6], s.c[7], s.c[8], s.c[9], s.c[10], s.c[11]};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_dist.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int count, int gap_pct);
    for (int n = 0; n < count; n++) send_pair(random_pair(), gap_pct);
    drain_results();
  endtask

  initial begin
    int dir[20][12];
    sb = new();
    idle_cycles = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    {in_s1sx, in_s1sy, in_s1sz, in_s1ex, in_s1ey, in_s1ez} <= '0;
    {in_s2sx, in_s2sy, in_s2sz, in_s2ex, in_s2ey, in_s2ez} <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768},
      '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768},
      '{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767},
      '{0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 5, 0},
      '{0, 0, 0, 10, 0, 0, 20, 0, 0, 30, 0, 0},
      '{0, 0, 0, 10, 0, 0, 3, 0, 0, 7, 0, 0},
      '{0, 0, 0, 10, 0, 0, -5, 3, 0, -1, 3, 0},
      '{5, 5, 5, 5, 5, 5, 0, 0, 0, 10, 0, 0},
      '{0, 0, 0, 10, 0, 0, 4, 4, 4, 4, 4, 4},
      '{1, 2, 3, 1, 2, 3, -7, 8, 9, -7, 8, 9},
      '{0, 0, 0, 10, 0, 0, 5, -5, 1, 5, 5, 1},
      '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0},
      '{0, 0, 0, 2, 0, 0, 1, 1, 0, 1, 1, 0},
      '{0, 0, 0, 10, 0, 0, 12, -3, 0, 15, 3, 0},
      '{0, 0, 0, 10, 0, 0, -4, -3, 0, -2, 3, 0},
      '{0, 0, 0, 3, 0, 0, 1, 1, 1, 2, 2, 2},
      '{-32768, 0, 0, 32767, 0, 0, 0, -32768, 1, 0, 32767, 1},
      '{32767, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, -32768, 32767, 0},
      '{0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0}
    };
    for (int n = 0; n < 20; n++) send_pair(make_pair(dir[n]), 0);
    drain_results();

    random_phase(180, 20);
    random_phase(180, 50);
    random_phase(190, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d segment pairs (directed extremes, parallel, degenerate, random)",
             sb.noted);
    $display("checked %0d distances, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_dist.size() == 0)
      $display("[segment_segment_distance_3d] OK");
    else
      $display("[segment_segment_distance_3d] ERROR");
    $finish;
  end

endmodule

[sim.f]
design/ssd_pkg.sv
design/ssd_dly.sv
design/ssd_mul.sv
design/ssd_frac.sv
design/ssd_sqrt.sv
design/segment_segment_distance_3d.sv
tb/tb_segment_segment_distance_3d.sv
